### hdl/pidaw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the PID controller with anti-windup.
// Depends on nothing; the controller and its checker import it.
package pidaw_pkg;

	// Fraction bits of the fixed-point format of gains, limits and samples.
	localparam int FRAC_BITS = 16;

	// Width of the configuration register index.
	localparam int CFG_INDEX_W = 3;

	// Register stages between an accepted input beat and its result beat.
	localparam int PIPE_DEPTH = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_LIMIT_HIGH  = 3'd3,
		REG_LIMIT_LOW   = 3'd4,
		REG_IDLE_OUTPUT = 3'd5,
		REG_RUN_ENABLE  = 3'd6
	} reg_index_t;

	// Clamp indication carried with every result.
	typedef enum logic [1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_HIGH = 2'd1,
		CLAMP_LOW  = 2'd2
	} clamp_code_t;

endpackage

### hdl/pid_controller_antiwindup.sv
`timescale 1ns / 1ps
// PID controller with back-calculation anti-windup on fixed-point error samples.
// Depends on pidaw_pkg for the register indexes, clamp codes and format constants.
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  ---------------------------
//   in       sink       in_valid / in_stall  error_sample
//   out      source     out_valid/out_stall  drive_value, clamp_state
//   cfg      sink       cfg_write            cfg_index, cfg_data
//
// The block takes one beat per cycle while in_stall is low and returns one
// result beat per input beat. Each beat passes through stage one, stage two
// and the output register, and its result is taken when the output is not
// stalled. Stage one registers the sample next to the previous sample, stage
// two holds the three gain products, and the output register closes the
// integral and windup feedback loop, so that loop sets the clock period.
// Asynchronous reset clears the valid flags, the controller state and the
// configuration registers to their reset values. A stall on the output fills
// the empty stages first; in_stall rises only when all three stages hold a beat.
module pid_controller_antiwindup
	import pidaw_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_write,
	input  logic [CFG_INDEX_W-1:0]       cfg_index,
	input  logic [DATA_WIDTH-1:0]        cfg_data,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] error_sample,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] drive_value,
	output logic [1:0]                   clamp_state
);

	// Product of a gain and a one-bit-wider sum or difference of samples.
	localparam int PW = 2 * DATA_WIDTH + 1;
	// Product after the fraction bits are dropped.
	localparam int QW = PW - FRAC_BITS;
	// Working width of the sums in the output stage, with headroom for three
	// terms and the overshoot subtraction.
	localparam int SW = QW + 3;

	localparam logic signed [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Saturates a wide signed value to the sample range.
	function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [SW-1:0] x);
		logic signed [DATA_WIDTH-1:0] r;
		if (x > SW'(MAX_V)) begin
			r = MAX_V;
		end else if (x < SW'(MIN_V)) begin
			r = MIN_V;
		end else begin
			r = DATA_WIDTH'(x);
		end
		return r;
	endfunction

	// Configuration registers.
	logic signed [DATA_WIDTH-1:0] prop_gain_q;
	logic signed [DATA_WIDTH-1:0] integ_gain_q;
	logic signed [DATA_WIDTH-1:0] deriv_gain_q;
	logic signed [DATA_WIDTH-1:0] limit_high_q;
	logic signed [DATA_WIDTH-1:0] limit_low_q;
	logic signed [DATA_WIDTH-1:0] idle_output_q;
	logic                         run_enable_q;

	// Controller state.
	logic signed [DATA_WIDTH-1:0] prev_q;
	logic signed [DATA_WIDTH-1:0] integral_q;
	logic signed [DATA_WIDTH-1:0] windup_q;

	// Pipeline.
	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] e_s1;
	logic signed [DATA_WIDTH-1:0] prev_s1;
	logic                         valid_s2;
	logic signed [QW-1:0]         p_s2;
	logic signed [QW-1:0]         ip_s2;
	logic signed [QW-1:0]         d_s2;
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] drive_value_q;
	clamp_code_t                  clamp_state_q;

	// Flow control.
	logic out_load;
	logic s2_load;
	logic s1_load;
	logic in_fire;

	assign out_load = !out_valid_q || !out_stall;
	assign s2_load  = !valid_s2 || out_load;
	assign s1_load  = !valid_s1 || s2_load;
	assign in_fire  = in_valid && s1_load;
	assign in_stall = !s1_load;

	// Configuration writes. Indexes past the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			limit_high_q  <= MAX_V;
			limit_low_q   <= MIN_V;
			idle_output_q <= '0;
			run_enable_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				REG_LIMIT_HIGH:  limit_high_q  <= cfg_data;
				REG_LIMIT_LOW:   limit_low_q   <= cfg_data;
				REG_IDLE_OUTPUT: idle_output_q <= cfg_data;
				REG_RUN_ENABLE:  run_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage one: the sample and the sample before it. The previous sample
	// only depends on the order of input beats, so it is tracked right here
	// and never waits for the feedback loop. A disabled beat clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prev_q   <= '0;
		end else begin
			if (s1_load) begin
				valid_s1 <= in_valid;
			end
			if (in_fire) begin
				prev_q <= run_enable_q ? error_sample : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			e_s1    <= error_sample;
			prev_s1 <= prev_q;
		end
	end

	// Stage two: the three gain products. Sum and difference of the samples
	// are kept one bit wider so they stay exact. The arithmetic shift floors.
	logic signed [DATA_WIDTH:0] sum_ep;
	logic signed [DATA_WIDTH:0] diff_ep;
	logic signed [PW-1:0]       prod_p;
	logic signed [PW-1:0]       prod_i;
	logic signed [PW-1:0]       prod_d;

	assign sum_ep  = (DATA_WIDTH+1)'(e_s1) + (DATA_WIDTH+1)'(prev_s1);
	assign diff_ep = (DATA_WIDTH+1)'(e_s1) - (DATA_WIDTH+1)'(prev_s1);
	assign prod_p  = PW'(prop_gain_q) * PW'(e_s1);
	assign prod_i  = PW'(integ_gain_q) * PW'(sum_ep);
	assign prod_d  = PW'(deriv_gain_q) * PW'(diff_ep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			p_s2  <= QW'(prod_p >>> FRAC_BITS);
			ip_s2 <= QW'(prod_i >>> FRAC_BITS);
			d_s2  <= QW'(prod_d >>> FRAC_BITS);
		end
	end

	// Output stage: integral with the last windup correction, the control sum,
	// the clamp and the new overshoot. With a zero integral gain the integral
	// term is zero and the stored integral holds.
	logic                         integ_off;
	logic signed [SW-1:0]         integ_wide;
	logic signed [DATA_WIDTH-1:0] integ_term;
	logic signed [DATA_WIDTH-1:0] integ_used;
	logic signed [SW-1:0]         y_wide;
	logic signed [SW-1:0]         over_wide;
	logic signed [DATA_WIDTH-1:0] y_clamped;
	clamp_code_t                  clamp_next;

	assign integ_off  = (integ_gain_q == '0);
	assign integ_wide = SW'(integral_q) + SW'(ip_s2) + SW'(windup_q);
	assign integ_term = sat_w(integ_wide);
	assign integ_used = integ_off ? '0 : integ_term;
	assign y_wide     = SW'(p_s2) + SW'(integ_used) + SW'(d_s2);

	// The high limit wins when the limits cross.
	always_comb begin
		priority if (y_wide > SW'(limit_high_q)) begin
			over_wide  = SW'(limit_high_q) - y_wide;
			y_clamped  = limit_high_q;
			clamp_next = CLAMP_HIGH;
		end else if (y_wide < SW'(limit_low_q)) begin
			over_wide  = SW'(limit_low_q) - y_wide;
			y_clamped  = limit_low_q;
			clamp_next = CLAMP_LOW;
		end else begin
			over_wide  = '0;
			y_clamped  = DATA_WIDTH'(y_wide);
			clamp_next = CLAMP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			integral_q  <= '0;
			windup_q    <= '0;
		end else if (out_load) begin
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				if (!run_enable_q) begin
					integral_q <= '0;
					windup_q   <= '0;
				end else begin
					if (!integ_off) begin
						integral_q <= integ_term;
					end
					windup_q <= sat_w(over_wide);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_value_q <= run_enable_q ? y_clamped : idle_output_q;
			clamp_state_q <= run_enable_q ? clamp_next : CLAMP_NONE;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_value = drive_value_q;
	assign clamp_state = clamp_state_q;

endmodule

### hdl/pidaw_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the PID controller and the bind that attaches them.
// Depends on pidaw_pkg for the pipeline depth.
module pidaw_checker
	import pidaw_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [DATA_WIDTH-1:0] drive_value,
	input logic [1:0]                   clamp_state
);

	// Beats accepted at the input whose results have not yet left.
	logic [2:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	// A result is only shown for a beat that came in.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != '0))
		else $error("result beat without a pending input beat");

	// The pipeline never holds more beats than it has stages.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'(PIPE_DEPTH))
		else $error("more beats pending than pipeline stages");

	// The input is held back only when every stage is full and the output waits.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (pending_q == 3'(PIPE_DEPTH) && out_valid && out_stall))
		else $error("input stalled while the pipeline has room");

	// A stalled result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(drive_value)
			&& $stable(clamp_state)))
		else $error("stalled result beat changed");

endmodule

bind pid_controller_antiwindup pidaw_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pidaw_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the PID controller with back-calculation anti-windup.
// Depends on pidaw_pkg and pid_controller_antiwindup; it needs nothing else.
module tb_top;
	import pidaw_pkg::*;

	localparam int DW = 32;

	// Full-precision working type of the predictor. Products of a 32-bit gain
	// and a 33-bit difference need 65 bits, so 80 leaves ample headroom.
	typedef logic signed [79:0] wide_t;

	localparam wide_t SAT_HI = 80'sd2147483647;
	localparam wide_t SAT_LO = -80'sd2147483648;

	localparam logic signed [DW-1:0] E_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DW-1:0] E_MIN = 32'sh8000_0000;

	// The index one past the register list; writes to it must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	// Length of the long receiver hold-off used to fill the pipeline.
	localparam int HOLD_CYCLES = 80;

	// One expected result beat.
	typedef struct packed {
		logic signed [DW-1:0] drive;
		clamp_code_t          clamp;
	} drive_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [DW-1:0]          cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic signed [DW-1:0]   error_sample = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [DW-1:0]   drive_value;
	logic [1:0]             clamp_state;

	pid_controller_antiwindup #(
		.DATA_WIDTH(DW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.error_sample(error_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_value (drive_value),
		.clamp_state (clamp_state)
	);

	// 20 ns clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The predictor's copy of the configuration registers, at their reset values.
	logic signed [DW-1:0] kp_cfg = '0;
	logic signed [DW-1:0] ki_cfg = '0;
	logic signed [DW-1:0] kd_cfg = '0;
	logic signed [DW-1:0] hi_cfg = E_MAX;
	logic signed [DW-1:0] lo_cfg = E_MIN;
	logic signed [DW-1:0] idle_cfg = '0;
	logic                 run_cfg = 1'b0;

	// The predictor's copy of the controller state.
	logic signed [DW-1:0] prev_err = '0;
	logic signed [DW-1:0] integ_acc = '0;
	logic signed [DW-1:0] windup = '0;

	// Drive values still owed by the block, oldest first.
	drive_beat_t pending_drives[$];

	int err_count = 0;

	// Idle percentages of each side and the long hold-off request. The hold is
	// raised by a test, and the receiver process itself counts it and lowers it.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_on = 1'b0;
	int          hold_count = 0;

	// Q16.16 product, formed exactly and floored by the arithmetic shift.
	function automatic wide_t q16_product(input logic signed [DW-1:0] gain, input wide_t v);
		wide_t g;
		g = gain;
		return (g * v) >>> FRAC_BITS;
	endfunction

	function automatic wide_t sat32(input wide_t x);
		if (x > SAT_HI)
			return SAT_HI;
		if (x < SAT_LO)
			return SAT_LO;
		return x;
	endfunction

	// Works out the result of one accepted error sample and advances the
	// predictor's state, exactly as the controller must.
	function automatic drive_beat_t predict_drive(input logic signed [DW-1:0] e);
		wide_t ew, pw, iw, dw, yw, hw, lw;
		drive_beat_t r;
		if (!run_cfg) begin
			// Disabled: the idle output goes out and the whole state is cleared.
			prev_err = '0;
			integ_acc = '0;
			windup = '0;
			r.drive = idle_cfg;
			r.clamp = CLAMP_NONE;
			return r;
		end
		ew = e;
		pw = q16_product(kp_cfg, ew);
		// A zero integral gain holds the integral and skips the correction.
		if (ki_cfg != 0) begin
			iw = sat32(integ_acc + q16_product(ki_cfg, ew + prev_err) + windup);
			integ_acc = iw[DW-1:0];
		end else begin
			iw = '0;
		end
		dw = q16_product(kd_cfg, ew - prev_err);
		prev_err = e;
		yw = pw + iw + dw;
		hw = hi_cfg;
		lw = lo_cfg;
		// The high limit wins, which settles the crossed-limit case.
		if (yw > hw) begin
			windup = sat32(hw - yw);
			r.drive = hi_cfg;
			r.clamp = CLAMP_HIGH;
		end else if (yw < lw) begin
			windup = sat32(lw - yw);
			r.drive = lo_cfg;
			r.clamp = CLAMP_LOW;
		end else begin
			windup = '0;
			r.drive = yw[DW-1:0];
			r.clamp = CLAMP_NONE;
		end
		return r;
	endfunction

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Output side. Everything here samples at the rising edge, before the block's
	// registers move, so it sees the same values the handshake was decided on.
	always @(posedge clk) begin : watch_beats
		drive_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_drives.size() == 0) begin
					flag_error($sformatf("result beat with nothing owed: drive %h clamp %0d",
						drive_value, clamp_state));
				end else begin
					want = pending_drives.pop_front();
					if (drive_value !== want.drive)
						flag_error($sformatf("drive_value: expected %h, got %h",
							want.drive, drive_value));
					if (clamp_state !== want.clamp)
						flag_error($sformatf("clamp_state: expected %0d, got %0d",
							want.clamp, clamp_state));
				end
			end
			// A beat accepted on this edge cannot come out on the same edge.
			if (in_valid && !in_stall)
				pending_drives.push_back(predict_drive(error_sample));
		end
	end

	// Receiver: random stalls, or one long stall while a hold-off is requested.
	always @(negedge clk) begin
		if (hold_on) begin
			out_stall <= 1'b1;
			hold_count++;
			if (hold_count >= HOLD_CYCLES) begin
				hold_on = 1'b0;
				hold_count = 0;
			end
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Writes one register and mirrors it in the predictor. Only called while
	// nothing is in flight. The idle cycle after the write keeps cfg_write from
	// being lowered and raised again within one time step.
	task automatic drive_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DW-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PROP_GAIN:   kp_cfg = val;
			REG_INTEG_GAIN:  ki_cfg = val;
			REG_DERIV_GAIN:  kd_cfg = val;
			REG_LIMIT_HIGH:  hi_cfg = val;
			REG_LIMIT_LOW:   lo_cfg = val;
			REG_IDLE_OUTPUT: idle_cfg = val;
			REG_RUN_ENABLE:  run_cfg = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_gains(input logic signed [DW-1:0] kp, ki, kd);
		drive_reg(REG_PROP_GAIN, kp);
		drive_reg(REG_INTEG_GAIN, ki);
		drive_reg(REG_DERIV_GAIN, kd);
	endtask

	task automatic set_limits(input logic signed [DW-1:0] hi, lo);
		drive_reg(REG_LIMIT_HIGH, hi);
		drive_reg(REG_LIMIT_LOW, lo);
	endtask

	// Offers one error sample beat and returns on the falling edge after it is
	// taken. Valid stays high on return so back-to-back beats need no gap.
	task automatic send_error(input logic signed [DW-1:0] e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		error_sample <= e;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Stops sending and waits until every owed result has come back.
	task automatic drain_drives();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_drives.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [DW-1:0] q16(input int whole);
		return whole * (1 << FRAC_BITS);
	endfunction

	// Uniform in [-span, span].
	function automatic logic signed [DW-1:0] rand_span(input int unsigned span);
		return DW'($urandom_range(0, 2 * span)) - DW'(span);
	endfunction

	function automatic logic signed [DW-1:0] draw_gain(input int unsigned span,
			input int unsigned zero_pct);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < zero_pct)
			return '0;
		if (pick < zero_pct + 15)
			return $urandom;
		return rand_span(span);
	endfunction

	function automatic logic signed [DW-1:0] draw_error();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return rand_span(50 << FRAC_BITS);
		if (pick < 80)
			return $urandom;
		if (pick < 92)
			return $urandom_range(1) ? E_MAX : E_MIN;
		return '0;
	endfunction

	// Right after reset the block is disabled with a zero idle output.
	task automatic test_after_reset();
		send_error(E_MAX);
		send_error(E_MIN);
		drain_drives();
	endtask

	// Disabled with a nonzero idle output. The enable is written with its upper
	// bits set and bit zero clear, which must still mean disabled.
	task automatic test_disabled_output();
		drive_reg(REG_IDLE_OUTPUT, $urandom | 32'h1);
		drive_reg(REG_RUN_ENABLE, 32'hFFFF_FFFE);
		send_error(q16(3));
		send_error(E_MIN);
		drain_drives();
	endtask

	// Proportional path alone at the extremes of sample and gain.
	task automatic test_proportional_extremes();
		set_gains(q16(1), '0, '0);
		drive_reg(REG_RUN_ENABLE, 32'h1);
		send_error(E_MAX);
		send_error(E_MIN);
		send_error(-32'sd1);
		send_error('0);
		drain_drives();
		// Largest gain times largest sample lands far above the high limit;
		// the most negative gain lands far below the low limit.
		drive_reg(REG_PROP_GAIN, E_MAX);
		send_error(E_MAX);
		drain_drives();
		drive_reg(REG_PROP_GAIN, E_MIN);
		send_error(E_MAX);
		drain_drives();
	endtask

	// Integral accumulation, hold under a zero integral gain, and saturation
	// of the stored integral.
	task automatic test_integral_path();
		set_gains('0, q16(1) >>> 1, '0);
		send_error(q16(10));
		send_error(q16(10));
		drain_drives();
		drive_reg(REG_INTEG_GAIN, '0);
		send_error(q16(5));
		drain_drives();
		drive_reg(REG_INTEG_GAIN, q16(1) >>> 1);
		send_error('0);
		drain_drives();
		drive_reg(REG_INTEG_GAIN, E_MAX);
		send_error(E_MAX);
		send_error(E_MAX);
		drain_drives();
	endtask

	// Derivative path with a full-scale swing, which needs the 33-bit difference.
	task automatic test_derivative_path();
		set_gains('0, '0, E_MAX);
		send_error(E_MAX);
		send_error(E_MIN);
		drain_drives();
		drive_reg(REG_DERIV_GAIN, E_MIN);
		send_error(E_MAX);
		drain_drives();
	endtask

	// Tight limits with windup feedback, crossed limits, and an overshoot too
	// large for 32 bits.
	task automatic test_windup_and_limits();
		set_gains(q16(1), q16(1), '0);
		set_limits(q16(1), q16(-1));
		send_error(q16(5));
		send_error(q16(5));
		send_error(q16(-5));
		drain_drives();
		set_limits(q16(-1), q16(1));
		send_error('0);
		send_error(q16(-5));
		send_error(q16(5));
		drain_drives();
		set_gains(E_MAX, '0, '0);
		set_limits(E_MIN, E_MIN);
		send_error(E_MAX);
		drain_drives();
	endtask

	// One phase of random traffic under a freshly drawn configuration. Most
	// phases run the control law with moderate gains so that the integral and
	// windup paths get exercised over long runs of samples.
	task automatic run_random_phase(input int n_items);
		int unsigned pick;
		logic [DW-1:0] en_word;
		set_gains(draw_gain(4 << FRAC_BITS, 15), draw_gain(1 << (FRAC_BITS - 1), 20),
			draw_gain(2 << FRAC_BITS, 20));
		pick = $urandom_range(99);
		if (pick < 15)
			set_limits(E_MAX, E_MIN);
		else if (pick < 25)
			set_limits(-$signed(DW'($urandom_range(0, 200 << FRAC_BITS))),
				DW'($urandom_range(0, 200 << FRAC_BITS)));
		else
			set_limits(DW'($urandom_range(0, 200 << FRAC_BITS)),
				-$signed(DW'($urandom_range(0, 200 << FRAC_BITS))));
		drive_reg(REG_IDLE_OUTPUT, $urandom);
		en_word = $urandom;
		en_word[0] = ($urandom_range(99) < 85);
		drive_reg(REG_RUN_ENABLE, en_word);
		for (int k = 0; k < n_items; k++)
			send_error(draw_error());
		drain_drives();
	endtask

	task automatic test_random_traffic(input int unsigned snd_pct, rcv_pct, input int phases);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int ph = 0; ph < phases; ph++)
			run_random_phase(50);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// beats, so the pipeline fills and in_stall rises. The sender then pauses
	// until every owed result is back.
	task automatic test_backpressure();
		send_idle_pct = 0;
		drive_reg(REG_RUN_ENABLE, 32'h1);
		hold_on = 1'b1;
		for (int k = 0; k < 30; k++)
			send_error(draw_error());
		drain_drives();
	endtask

	initial begin : main_seq
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 47;
		test_after_reset();
		test_disabled_output();
		test_proportional_extremes();
		test_integral_path();
		test_derivative_path();
		test_windup_and_limits();

		// A write past the register list must change nothing that follows.
		drive_reg(REG_UNUSED, $urandom);
		test_random_traffic(23, 47, 4);
		test_backpressure();
		test_random_traffic(47, 23, 4);
		test_random_traffic(0, 0, 2);

		// Watch a little longer for stray result beats.
		drain_drives();
		repeat (PIPE_DEPTH + 8) @(negedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// A hang anywhere ends the run as a failure; the normal run is far shorter.
	initial begin : watchdog
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

### files.f
hdl/pidaw_pkg.sv
hdl/pid_controller_antiwindup.sv
hdl/pidaw_checker.sv
tb/sv/tb_top.sv
